// ----- rtl/core/grlp_pkg.sv -----
`timescale 1ns / 1ps

package grlp_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;

    // Characters of the genotype text
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Allele codes
    localparam logic [2:0] AL_NONE = 3'd0;
    localparam logic [2:0] AL_A    = 3'd1;
    localparam logic [2:0] AL_C    = 3'd2;
    localparam logic [2:0] AL_G    = 3'd3;
    localparam logic [2:0] AL_T    = 3'd4;
    localparam logic [2:0] AL_D    = 3'd5;
    localparam logic [2:0] AL_I    = 3'd6;
    localparam logic [2:0] AL_MAX  = AL_I;

    // Chromosome codes
    localparam logic [4:0] CHR_NONE    = 5'd0;
    localparam logic [4:0] CHR_X       = 5'd23;
    localparam logic [4:0] CHR_Y       = 5'd24;
    localparam logic [4:0] CHR_MT      = 5'd25;
    localparam logic [4:0] CHR_MAX     = CHR_MT;
    localparam logic [4:0] CHR_TOO_BIG = 5'd31;

    typedef enum logic [11:0] {
        PH_LINE_START   = 12'b0000_0000_0001,
        PH_SKIP_LINE    = 12'b0000_0000_0010,
        PH_RS_SKIP      = 12'b0000_0000_0100,
        PH_RSID         = 12'b0000_0000_1000,
        PH_WS_CHROM     = 12'b0000_0001_0000,
        PH_M_SKIP       = 12'b0000_0010_0000,
        PH_WS_POS       = 12'b0000_0100_0000,
        PH_POS          = 12'b0000_1000_0000,
        PH_WS_GENO      = 12'b0001_0000_0000,
        PH_ALLELE2      = 12'b0010_0000_0000,
        PH_SKIP_ONE     = 12'b0100_0000_0000,
        PH_CHROM_DIGITS = 12'b1000_0000_0000
    } phase_t;

    // One record; rsid sits in the lowest bits.
    typedef struct packed {
        logic        y_seen;
        logic [31:0] highest_rsid;
        logic [31:0] lowest_rsid;
        logic [2:0]  allele_second;
        logic [2:0]  allele_first;
        logic [31:0] position;
        logic [4:0]  chromosome;
        logic [31:0] rsid;
    } record_t;

    localparam int REC_W     = $bits(record_t);
    localparam int M_TDATA_W = ((REC_W + 7) / 8) * 8;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_white(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic [2:0] allele_code(input logic [7:0] b);
        logic [2:0] code;
        case (b)
            CH_A: code = AL_A;
            CH_C: code = AL_C;
            CH_G: code = AL_G;
            CH_T: code = AL_T;
            CH_D: code = AL_D;
            CH_I: code = AL_I;
            default: code = AL_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/grlp_parser.sv -----
`timescale 1ns / 1ps

module grlp_parser
    import grlp_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_take,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       rec_valid,
    output record_t    rec
);

    localparam int NW = NUMBER_WIDTH;

    phase_t          phase_reg, phase_next;
    logic [NW-1:0]   rsid_reg, rsid_next;
    logic [4:0]      chrom_reg, chrom_next;
    logic [NW-1:0]   pos_reg, pos_next;
    logic [2:0]      a1_reg, a1_next;
    logic [2:0]      a2_reg, a2_next;
    logic [31:0]     min_reg, min_next;
    logic [31:0]     max_reg, max_next;
    logic            y_reg, y_next;

    logic            digit;
    logic            white;
    logic [3:0]      dval;
    logic            fall;
    phase_t          fall_ph;
    logic            emit_line;
    logic            emit_end;
    logic            emit_any;
    logic [31:0]     rsid_low;
    logic [8:0]      chrom_wide;
    logic [NW-1:0]   rsid_step;
    logic [NW-1:0]   pos_step;

    assign digit = is_digit(text_byte);
    assign white = is_white(text_byte);
    assign dval  = text_byte[3:0];

    // acc * 10 + digit, built from two shifts
    assign rsid_step = {rsid_reg[NW-4:0], 3'b000} + {rsid_reg[NW-2:0], 1'b0} + NW'(dval);
    assign pos_step  = {pos_reg[NW-4:0], 3'b000} + {pos_reg[NW-2:0], 1'b0} + NW'(dval);
    assign chrom_wide = {1'b0, chrom_reg, 3'b000} + {3'b000, chrom_reg, 1'b0} + 9'(dval);

    always_comb begin
        phase_next = phase_reg;
        rsid_next  = rsid_reg;
        chrom_next = chrom_reg;
        pos_next   = pos_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        y_next     = y_reg;
        fall       = 1'b0;
        fall_ph    = PH_WS_CHROM;
        emit_line  = 1'b0;

        case (phase_reg)
            PH_LINE_START: begin
                if (text_byte == CH_R) begin
                    rsid_next  = '0;
                    chrom_next = CHR_NONE;
                    pos_next   = '0;
                    a1_next    = AL_NONE;
                    a2_next    = AL_NONE;
                    phase_next = PH_RS_SKIP;
                end else if (text_byte != CH_LF) begin
                    phase_next = PH_SKIP_LINE;
                end
            end
            PH_SKIP_LINE: begin
                if (text_byte == CH_LF) begin
                    phase_next = PH_LINE_START;
                end
            end
            PH_RS_SKIP: begin
                phase_next = PH_RSID;
            end
            PH_RSID: begin
                if (digit) begin
                    rsid_next = rsid_step;
                end else begin
                    fall    = 1'b1;
                    fall_ph = PH_WS_CHROM;
                end
            end
            PH_WS_CHROM: begin
                fall    = 1'b1;
                fall_ph = PH_WS_CHROM;
            end
            PH_CHROM_DIGITS: begin
                if (digit) begin
                    chrom_next = (chrom_wide > 9'(CHR_MAX)) ? CHR_TOO_BIG : chrom_wide[4:0];
                end else begin
                    fall    = 1'b1;
                    fall_ph = PH_WS_POS;
                end
            end
            PH_M_SKIP: begin
                phase_next = PH_WS_POS;
            end
            PH_WS_POS: begin
                fall    = 1'b1;
                fall_ph = PH_WS_POS;
            end
            PH_POS: begin
                if (digit) begin
                    pos_next = pos_step;
                end else begin
                    fall    = 1'b1;
                    fall_ph = PH_WS_GENO;
                end
            end
            PH_WS_GENO: begin
                fall    = 1'b1;
                fall_ph = PH_WS_GENO;
            end
            PH_ALLELE2: begin
                if (text_byte == CH_LF || text_byte == CH_CR) begin
                    a2_next    = AL_NONE;
                    phase_next = (text_byte == CH_LF) ? PH_LINE_START : PH_SKIP_LINE;
                end else begin
                    a2_next    = allele_code(text_byte);
                    phase_next = PH_SKIP_ONE;
                end
                emit_line = 1'b1;
            end
            PH_SKIP_ONE: begin
                phase_next = PH_LINE_START;
            end
            default: begin
                phase_next = PH_LINE_START;
            end
        endcase

        // A byte that ends one field is handed on to the following field in
        // the same cycle; the handlers run in field order.
        if (fall && fall_ph == PH_WS_CHROM) begin
            phase_next = PH_WS_CHROM;
            if (!white) begin
                if (digit) begin
                    chrom_next = 5'(dval);
                    phase_next = PH_CHROM_DIGITS;
                end else if (text_byte == CH_M) begin
                    chrom_next = CHR_MT;
                    phase_next = PH_M_SKIP;
                end else begin
                    if (text_byte == CH_X) begin
                        chrom_next = CHR_X;
                    end else if (text_byte == CH_Y) begin
                        chrom_next = CHR_Y;
                        y_next     = 1'b1;
                    end else begin
                        chrom_next = CHR_NONE;
                    end
                    phase_next = PH_WS_POS;
                end
            end
        end

        if (fall && fall_ph == PH_WS_POS) begin
            phase_next = PH_WS_POS;
            if (!white) begin
                if (digit) begin
                    pos_next   = NW'(dval);
                    phase_next = PH_POS;
                end else begin
                    fall_ph = PH_WS_GENO;
                end
            end
        end

        if (fall && fall_ph == PH_WS_GENO) begin
            phase_next = PH_WS_GENO;
            if (!white) begin
                a1_next    = allele_code(text_byte);
                phase_next = PH_ALLELE2;
            end
        end

        // The final byte flushes a record that was started but not reported.
        emit_end = end_of_text && !emit_line && (phase_next != PH_LINE_START)
                   && (phase_next != PH_SKIP_LINE) && (phase_next != PH_SKIP_ONE);
        emit_any = emit_line || emit_end;

        rsid_low = 32'(rsid_next);
        if (emit_any) begin
            if (rsid_low < min_reg) begin
                min_next = rsid_low;
            end
            if (rsid_low > max_reg) begin
                max_next = rsid_low;
            end
        end

        rec.rsid          = rsid_low;
        rec.chromosome    = (chrom_next > CHR_MAX) ? CHR_NONE : chrom_next;
        rec.position      = 32'(pos_next);
        rec.allele_first  = a1_next;
        rec.allele_second = a2_next;
        rec.lowest_rsid   = min_next;
        rec.highest_rsid  = max_next;
        rec.y_seen        = y_next;

        if (emit_any || end_of_text) begin
            rsid_next  = '0;
            chrom_next = CHR_NONE;
            pos_next   = '0;
            a1_next    = AL_NONE;
            a2_next    = AL_NONE;
        end
        if (end_of_text) begin
            phase_next = PH_LINE_START;
        end
    end

    assign rec_valid = in_take && emit_any;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LINE_START;
            rsid_reg  <= '0;
            chrom_reg <= CHR_NONE;
            pos_reg   <= '0;
            a1_reg    <= AL_NONE;
            a2_reg    <= AL_NONE;
            min_reg   <= '1;
            max_reg   <= '0;
            y_reg     <= 1'b0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            rsid_reg  <= rsid_next;
            chrom_reg <= chrom_next;
            pos_reg   <= pos_next;
            a1_reg    <= a1_next;
            a2_reg    <= a2_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            y_reg     <= y_next;
        end
    end

endmodule

// ----- rtl/core/genotype_record_line_parser.sv -----
`timescale 1ns / 1ps
// A record appears on m_tvalid in the cycle after the transfer of the byte that ends it.
// Throughput: one byte per cycle; the parse state updates in the cycle a byte is taken,
// and a single output register holds the record while the next bytes keep flowing.
// A byte is stalled only while a record waits in the output register and m_tready is low.
// Reset (aresetn low, synchronous) returns the parser to line start, clears the record
// and the Y flag, sets the lowest rsid to all ones and the highest to zero.

module genotype_record_line_parser
    import grlp_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // text_byte
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rsid, chromosome, position, allele_first, allele_second, lowest_rsid,
    // highest_rsid, y_seen, then zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    take;
    logic    rec_valid;
    record_t rec;
    logic    m_tvalid_reg;
    record_t out_rec_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    grlp_parser #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_take     (take),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take && rec_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && rec_valid) begin
            out_rec_reg <= rec;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_rec_reg);

    // The tracked range always covers the record that is shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_rec_reg.lowest_rsid <= out_rec_reg.rsid)
                         && (out_rec_reg.rsid <= out_rec_reg.highest_rsid))
        else $error("reported rsid outside tracked range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_rec_reg.chromosome <= CHR_MAX)
                         && (out_rec_reg.allele_first <= AL_MAX)
                         && (out_rec_reg.allele_second <= AL_MAX))
        else $error("record code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(out_rec_reg))
        else $error("held record changed under back-pressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tvalid && $past(m_tvalid_reg && out_rec_reg.y_seen))
            |-> out_rec_reg.y_seen)
        else $error("Y flag cleared between records");

endmodule
